// ===== hw/rtl/pjw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and index tables of the prism Jacobian inverse core.
package pjw_pkg;

   localparam int DATA_W            = 32;
   localparam int SUM_W             = 64;
   localparam int VOL_W             = 31;
   localparam int NODES_DEFAULT     = 6;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int ENTRIES           = 9;
   localparam int IDX_W             = 4;
   localparam int QUEUE_DEPTH       = 2;
   localparam int QUEUE_PTR_W       = 1;
   localparam int QUEUE_CNT_W       = 2;
   localparam int DIV_CNT_W         = 6;

   localparam logic [VOL_W-1:0]  VOL_RESET   = 31'd65536;
   localparam logic [IDX_W-1:0]  LAST_ENTRY  = 4'd8;
   localparam logic [IDX_W-1:0]  WEIGHT_STEP = 4'd9;
   localparam logic [IDX_W-1:0]  LAST_COL0   = 4'd2;
   localparam logic signed [63:0] MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] MIN64 = 64'sh8000_0000_0000_0000;
   localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

   // One node as it travels from the front to the back.
   typedef struct packed {
      logic signed [DATA_W-1:0] coord_x;
      logic signed [DATA_W-1:0] coord_y;
      logic signed [DATA_W-1:0] coord_z;
      logic signed [DATA_W-1:0] grad_xi;
      logic signed [DATA_W-1:0] grad_eta;
      logic signed [DATA_W-1:0] grad_zeta;
      logic signed [DATA_W-1:0] point_weight;
      logic                     last;
   } node_type;

   // Queue occupancy seen by both sides.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Request to the shared divider.
   typedef struct packed {
      logic              start;
      logic              negate;
      logic [63:0]       dividend;
      logic [31:0]       divisor;
   } div_req_type;

   // Four Jacobian entries whose products form one cofactor.
   typedef struct packed {
      logic [IDX_W-1:0] a;
      logic [IDX_W-1:0] b;
      logic [IDX_W-1:0] c;
      logic [IDX_W-1:0] d;
   } cof_ix_type;

   // Cofactor k (row-major) is J[a]*J[b] - J[c]*J[d].
   function automatic cof_ix_type cof_index(input logic [IDX_W-1:0] k);
      cof_ix_type r;
      r = '0;
      unique case (k)
         4'd0: r = '{4'd4, 4'd8, 4'd5, 4'd7};
         4'd1: r = '{4'd5, 4'd6, 4'd3, 4'd8};
         4'd2: r = '{4'd3, 4'd7, 4'd4, 4'd6};
         4'd3: r = '{4'd7, 4'd2, 4'd8, 4'd1};
         4'd4: r = '{4'd8, 4'd0, 4'd6, 4'd2};
         4'd5: r = '{4'd6, 4'd1, 4'd7, 4'd0};
         4'd6: r = '{4'd1, 4'd5, 4'd2, 4'd4};
         4'd7: r = '{4'd2, 4'd3, 4'd0, 4'd5};
         4'd8: r = '{4'd0, 4'd4, 4'd1, 4'd3};
         default: r = '0;
      endcase
      return r;
   endfunction

   // Inverse entry k takes the cofactor at the transposed place.
   function automatic logic [IDX_W-1:0] transpose_index(input logic [IDX_W-1:0] k);
      logic [IDX_W-1:0] r;
      r = '0;
      unique case (k)
         4'd0: r = 4'd0;
         4'd1: r = 4'd3;
         4'd2: r = 4'd6;
         4'd3: r = 4'd1;
         4'd4: r = 4'd4;
         4'd5: r = 4'd7;
         4'd6: r = 4'd2;
         4'd7: r = 4'd5;
         4'd8: r = 4'd8;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/prism_jacobian_inverse_and_weight_core.sv =====
`timescale 1ns / 1ps
// Top level of the prism Jacobian inverse and point weight core.
//
//   channel  prefix  direction  beat
//   node     req_    in         one node: coordinates, gradient, point weight
//   result   rsp_    out        inverse Jacobian, determinant, weight, singular flag
//   volume   csr_    in         element volume write
//
// In the back end each node beat is taken from the queue, then folded in by nine
// multiply-accumulates on the one shared multiplier. After the last node of a point
// the solve makes ten passes of the bit-serial divider, which forms a 64-bit quotient.
// A two-entry queue lets the front keep taking node beats while the back works
// or waits on rsp_stall. Reset is synchronous and clears the node count and sums.
module prism_jacobian_inverse_and_weight_core import pjw_pkg::*; #(
   parameter int NODES_PER_ELEMENT = NODES_DEFAULT,
   parameter int FRACTION_BITS     = FRAC_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_coord_x,
   input  logic signed [DATA_W-1:0] req_coord_y,
   input  logic signed [DATA_W-1:0] req_coord_z,
   input  logic signed [DATA_W-1:0] req_grad_xi,
   input  logic signed [DATA_W-1:0] req_grad_eta,
   input  logic signed [DATA_W-1:0] req_grad_zeta,
   input  logic signed [DATA_W-1:0] req_point_weight,
   input  logic                     csr_wr_en,
   input  logic [VOL_W-1:0]         csr_wr_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_inv_00,
   output logic signed [DATA_W-1:0] rsp_inv_01,
   output logic signed [DATA_W-1:0] rsp_inv_02,
   output logic signed [DATA_W-1:0] rsp_inv_10,
   output logic signed [DATA_W-1:0] rsp_inv_11,
   output logic signed [DATA_W-1:0] rsp_inv_12,
   output logic signed [DATA_W-1:0] rsp_inv_20,
   output logic signed [DATA_W-1:0] rsp_inv_21,
   output logic signed [DATA_W-1:0] rsp_inv_22,
   output logic signed [DATA_W-1:0] rsp_jacobian_det,
   output logic signed [DATA_W-1:0] rsp_scaled_weight,
   output logic                     rsp_singular
);

   node_type     push_data;
   node_type     pop_data;
   logic         push;
   logic         pop;
   q_status_type q_status;

   pjw_front #(
      .NODES_PER_ELEMENT (NODES_PER_ELEMENT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_coord_z      (req_coord_z),
      .req_grad_xi      (req_grad_xi),
      .req_grad_eta     (req_grad_eta),
      .req_grad_zeta    (req_grad_zeta),
      .req_point_weight (req_point_weight),
      .q_status         (q_status),
      .push             (push),
      .push_data        (push_data)
   );

   pjw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   pjw_back #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_data            (pop_data),
      .q_status          (q_status),
      .q_pop             (pop),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_inv_00        (rsp_inv_00),
      .rsp_inv_01        (rsp_inv_01),
      .rsp_inv_02        (rsp_inv_02),
      .rsp_inv_10        (rsp_inv_10),
      .rsp_inv_11        (rsp_inv_11),
      .rsp_inv_12        (rsp_inv_12),
      .rsp_inv_20        (rsp_inv_20),
      .rsp_inv_21        (rsp_inv_21),
      .rsp_inv_22        (rsp_inv_22),
      .rsp_jacobian_det  (rsp_jacobian_det),
      .rsp_scaled_weight (rsp_scaled_weight),
      .rsp_singular      (rsp_singular)
   );

`ifndef SYNTHESIS
   // A full queue must hold off the node channel.
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> req_stall)
      else $error("queue full but node channel not stalled");

   // The singular flag tracks a zero determinant.
   a_singular_det: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_singular == (rsp_jacobian_det == '0)))
      else $error("singular flag disagrees with determinant");

   // A singular point carries a zero weight.
   a_singular_weight: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_singular) |-> (rsp_scaled_weight == '0))
      else $error("singular point with nonzero weight");
`endif

endmodule

// ===== hw/rtl/pjw_queue.sv =====
`timescale 1ns / 1ps
// Two-entry node queue between the front and the back.
module pjw_queue import pjw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  node_type     push_data,
   input  logic         pop,
   output node_type     pop_data,
   output q_status_type status
);

   node_type                 mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// ===== hw/rtl/pjw_front.sv =====
`timescale 1ns / 1ps
// Front end: takes node beats, tags the last node of a point, feeds the queue.
module pjw_front import pjw_pkg::*; #(
   parameter int NODES_PER_ELEMENT = NODES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_coord_x,
   input  logic signed [DATA_W-1:0] req_coord_y,
   input  logic signed [DATA_W-1:0] req_coord_z,
   input  logic signed [DATA_W-1:0] req_grad_xi,
   input  logic signed [DATA_W-1:0] req_grad_eta,
   input  logic signed [DATA_W-1:0] req_grad_zeta,
   input  logic signed [DATA_W-1:0] req_point_weight,
   input  q_status_type             q_status,
   output logic                     push,
   output node_type                 push_data
);

   localparam int CNT_W = $clog2(NODES_PER_ELEMENT);
   localparam logic [CNT_W-1:0] LAST_NODE = CNT_W'(NODES_PER_ELEMENT - 1);

   logic [CNT_W-1:0] node_cnt_ff, node_cnt_in;
   logic             is_last;

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;
   assign is_last   = (node_cnt_ff == LAST_NODE);

   // Node counter wraps after the last node of a point.
   always_comb begin
      node_cnt_in = node_cnt_ff;
      if (push) begin
         node_cnt_in = is_last ? '0 : node_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_cnt_ff <= '0;
      end else begin
         node_cnt_ff <= node_cnt_in;
      end
   end

   assign push_data = '{req_coord_x, req_coord_y, req_coord_z, req_grad_xi,
                        req_grad_eta, req_grad_zeta, req_point_weight, is_last};

endmodule

// ===== hw/rtl/pjw_div.sv =====
`timescale 1ns / 1ps
// Shared restoring divider: 64-bit magnitude by 32-bit magnitude, one bit a cycle.
module pjw_div import pjw_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  div_req_type              req,
   output logic                     done,
   output logic signed [DATA_W-1:0] quotient
);

   logic [63:0]          q_ff, q_in;
   logic [31:0]          rem_ff, rem_in;
   logic [31:0]          dvs_ff, dvs_in;
   logic                 neg_ff, neg_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [32:0]          rem_sh;
   logic [32:0]          rem_sub;
   logic                 ge;
   logic                 pos_over;
   logic                 neg_over;

   // One quotient bit per cycle.
   assign rem_sh  = {rem_ff, q_ff[63]};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};
   assign ge      = (rem_sh >= {1'b0, dvs_ff});

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      if (req.start) begin
         q_in    = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
         neg_in  = req.negate;
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '1;
      end else if (busy_ff) begin
         q_in   = {q_ff[62:0], ge};
         rem_in = ge ? rem_sub[31:0] : rem_sh[31:0];
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   // Apply the sign and saturate the quotient to 32 bits.
   assign pos_over = |q_ff[63:31];
   assign neg_over = (|q_ff[63:32]) || (q_ff[31] && (|q_ff[30:0]));

   always_comb begin
      if (neg_ff) begin
         quotient = neg_over ? MIN32 : -$signed(q_ff[31:0]);
      end else begin
         quotient = pos_over ? MAX32 : $signed(q_ff[31:0]);
      end
   end

   assign done = done_ff;

endmodule

// ===== hw/rtl/pjw_back.sv =====
`timescale 1ns / 1ps
// Back end: accumulates the Jacobian, forms cofactors, determinant and divisions.
module pjw_back import pjw_pkg::*; #(
   parameter int FRACTION_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  node_type                 q_data,
   input  q_status_type             q_status,
   output logic                     q_pop,
   input  logic                     csr_wr_en,
   input  logic [VOL_W-1:0]         csr_wr_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_inv_00,
   output logic signed [DATA_W-1:0] rsp_inv_01,
   output logic signed [DATA_W-1:0] rsp_inv_02,
   output logic signed [DATA_W-1:0] rsp_inv_10,
   output logic signed [DATA_W-1:0] rsp_inv_11,
   output logic signed [DATA_W-1:0] rsp_inv_12,
   output logic signed [DATA_W-1:0] rsp_inv_20,
   output logic signed [DATA_W-1:0] rsp_inv_21,
   output logic signed [DATA_W-1:0] rsp_inv_22,
   output logic signed [DATA_W-1:0] rsp_jacobian_det,
   output logic signed [DATA_W-1:0] rsp_scaled_weight,
   output logic                     rsp_singular
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MAC   = 7'b0000010,
      ST_ROUND = 7'b0000100,
      ST_COF   = 7'b0001000,
      ST_DET   = 7'b0010000,
      ST_DIV   = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type                state_ff, state_in;
   logic [2:0]               ph_ff, ph_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [1:0]               row_ff, row_in;
   logic [1:0]               col_ff, col_in;
   logic signed [31:0]       x_ff [3];
   logic signed [31:0]       x_in [3];
   logic signed [31:0]       g_ff [3];
   logic signed [31:0]       g_in [3];
   logic signed [31:0]       w_ff, w_in;
   logic                     last_ff, last_in;
   logic signed [63:0]       sum_ff [ENTRIES];
   logic signed [63:0]       sum_in [ENTRIES];
   logic signed [31:0]       jq_ff [ENTRIES];
   logic signed [31:0]       jq_in [ENTRIES];
   logic signed [63:0]       cof_ff [ENTRIES];
   logic signed [63:0]       cof_in [ENTRIES];
   logic signed [31:0]       res_ff [ENTRIES + 1];
   logic signed [31:0]       res_in [ENTRIES + 1];
   logic signed [63:0]       opa_ff, opa_in;
   logic signed [65:0]       p1_ff, p1_in;
   logic signed [65:0]       prod_ff, prod_in;
   logic signed [127:0]      acc_ff, acc_in;
   logic signed [31:0]       det_ff, det_in;
   logic [VOL_W-1:0]         vol_ff;
   logic [VOL_W-1:0]         vol_eff;
   logic signed [32:0]       mul_a;
   logic signed [32:0]       mul_b;
   logic signed [65:0]       mul_p;
   cof_ix_type               cix;
   logic signed [127:0]      prod_ext;
   div_req_type              div_req;
   logic                     div_done;
   logic signed [31:0]       div_quot;

   // Saturating add of a product into a 64-bit sum.
   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [65:0] p);
      logic signed [64:0] s;
      s = {a[63], a} + p[64:0];
      if (s[64] != s[63]) begin
         return s[64] ? MIN64 : MAX64;
      end
      return s[63:0];
   endfunction

   // Difference of two products, saturated to 64 bits.
   function automatic logic signed [63:0] sat_diff64(input logic signed [65:0] p,
                                                     input logic signed [65:0] q);
      logic signed [65:0] d;
      d = p - q;
      if (!((&d[65:63]) || !(|d[65:63]))) begin
         return d[65] ? MIN64 : MAX64;
      end
      return d[63:0];
   endfunction

   // Round half up by the fraction width and saturate to 32 bits.
   function automatic logic signed [31:0] round_entry(input logic signed [63:0] v);
      logic signed [64:0] t;
      t = {v[63], v} + (65'sd1 <<< (FRACTION_BITS - 1));
      t = t >>> FRACTION_BITS;
      if (!((&t[64:31]) || !(|t[64:31]))) begin
         return t[64] ? MIN32 : MAX32;
      end
      return t[31:0];
   endfunction

   // Round half up by twice the fraction width and saturate to 32 bits.
   function automatic logic signed [31:0] round_det(input logic signed [127:0] v);
      logic signed [127:0] t;
      t = v + (128'sd1 <<< (2 * FRACTION_BITS - 1));
      t = t >>> (2 * FRACTION_BITS);
      if (!((&t[127:31]) || !(|t[127:31]))) begin
         return t[127] ? MIN32 : MAX32;
      end
      return t[31:0];
   endfunction

   pjw_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Volume register; zero acts as one unit step.
   always_ff @(posedge clock) begin
      if (reset) begin
         vol_ff <= VOL_RESET;
      end else if (csr_wr_en) begin
         vol_ff <= csr_wr_data;
      end
   end

   assign vol_eff = (vol_ff == '0) ? VOL_W'(1) : vol_ff;

   assign cix      = cof_index(idx_ff);
   assign prod_ext = {{62{prod_ff[65]}}, prod_ff};

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MAC: begin
            mul_a = {x_ff[row_ff][31], x_ff[row_ff]};
            mul_b = {g_ff[col_ff][31], g_ff[col_ff]};
         end
         ST_COF: begin
            mul_a = opa_ff[32:0];
            mul_b = (ph_ff == 3'd1) ? {jq_ff[cix.b][31], jq_ff[cix.b]}
                                    : {jq_ff[cix.d][31], jq_ff[cix.d]};
         end
         ST_DET: begin
            mul_a = {jq_ff[idx_ff][31], jq_ff[idx_ff]};
            mul_b = (ph_ff == 3'd1) ? {1'b0, opa_ff[31:0]} : {opa_ff[63], opa_ff[63:32]};
         end
         ST_DIV: begin
            mul_a = {w_ff[31], w_ff};
            mul_b = {det_ff[31], det_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      ph_in    = ph_ff;
      idx_in   = idx_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      x_in     = x_ff;
      g_in     = g_ff;
      w_in     = w_ff;
      last_in  = last_ff;
      sum_in   = sum_ff;
      jq_in    = jq_ff;
      cof_in   = cof_ff;
      res_in   = res_ff;
      opa_in   = opa_ff;
      p1_in    = p1_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      det_in   = det_ff;
      q_pop    = 1'b0;
      div_req  = '0;
      unique case (state_ff)
         // Take the next node from the queue.
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               x_in[0]  = q_data.coord_x;
               x_in[1]  = q_data.coord_y;
               x_in[2]  = q_data.coord_z;
               g_in[0]  = q_data.grad_xi;
               g_in[1]  = q_data.grad_eta;
               g_in[2]  = q_data.grad_zeta;
               w_in     = q_data.point_weight;
               last_in  = q_data.last;
               state_in = ST_MAC;
               ph_in    = '0;
               idx_in   = '0;
               row_in   = '0;
               col_in   = '0;
            end
         end
         // One outer-product term: multiply, then accumulate.
         ST_MAC: begin
            if (ph_ff == 3'd0) begin
               prod_in = mul_p;
               ph_in   = 3'd1;
            end else begin
               sum_in[idx_ff] = sat_add64(sum_ff[idx_ff], prod_ff);
               ph_in          = 3'd0;
               if (col_ff == 2'd2) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
               if (idx_ff == LAST_ENTRY) begin
                  idx_in   = '0;
                  state_in = last_ff ? ST_ROUND : ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         // Round all entries and clear the sums for the next point.
         ST_ROUND: begin
            for (int k = 0; k < ENTRIES; k++) begin
               jq_in[k]  = round_entry(sum_ff[k]);
               sum_in[k] = '0;
            end
            state_in = ST_COF;
            idx_in   = '0;
            ph_in    = '0;
         end
         // Cofactor: two products and a saturated difference.
         ST_COF: begin
            unique case (ph_ff)
               3'd0: begin
                  opa_in = {{32{jq_ff[cix.a][31]}}, jq_ff[cix.a]};
                  ph_in  = 3'd1;
               end
               3'd1: begin
                  prod_in = mul_p;
                  ph_in   = 3'd2;
               end
               3'd2: begin
                  p1_in  = prod_ff;
                  opa_in = {{32{jq_ff[cix.c][31]}}, jq_ff[cix.c]};
                  ph_in  = 3'd3;
               end
               3'd3: begin
                  prod_in = mul_p;
                  ph_in   = 3'd4;
               end
               3'd4: begin
                  cof_in[idx_ff] = sat_diff64(p1_ff, prod_ff);
                  ph_in          = 3'd0;
                  if (idx_ff == LAST_ENTRY) begin
                     idx_in   = '0;
                     acc_in   = '0;
                     state_in = ST_DET;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               default: ph_in = 3'd0;
            endcase
         end
         // Determinant by first-row expansion, 64-bit cofactor in two halves.
         ST_DET: begin
            unique case (ph_ff)
               3'd0: begin
                  opa_in = cof_ff[idx_ff];
                  ph_in  = 3'd1;
               end
               3'd1: begin
                  prod_in = mul_p;
                  ph_in   = 3'd2;
               end
               3'd2: begin
                  acc_in  = acc_ff + prod_ext;
                  prod_in = mul_p;
                  ph_in   = 3'd3;
               end
               3'd3: begin
                  acc_in = acc_ff + (prod_ext <<< 32);
                  if (idx_ff == LAST_COL0) begin
                     ph_in = 3'd4;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                     ph_in  = 3'd0;
                  end
               end
               3'd4: begin
                  det_in   = round_det(acc_ff);
                  idx_in   = '0;
                  ph_in    = 3'd0;
                  state_in = ST_DIV;
               end
               default: ph_in = 3'd0;
            endcase
         end
         // Nine inverse entries, then the scaled weight, through the divider.
         ST_DIV: begin
            unique case (ph_ff)
               3'd0: begin
                  if (idx_ff == WEIGHT_STEP) begin
                     prod_in = mul_p;
                  end else begin
                     opa_in = cof_ff[transpose_index(idx_ff)];
                  end
                  ph_in = 3'd1;
               end
               3'd1: begin
                  div_req.start = 1'b1;
                  if (idx_ff == WEIGHT_STEP) begin
                     div_req.negate   = prod_ff[63];
                     div_req.dividend = prod_ff[63] ? -prod_ff[63:0] : prod_ff[63:0];
                     div_req.divisor  = {vol_eff, 1'b0};
                  end else begin
                     div_req.negate   = opa_ff[63] ^ det_ff[31];
                     div_req.dividend = opa_ff[63] ? -opa_ff : opa_ff;
                     div_req.divisor  = det_ff[31] ? -det_ff : det_ff;
                  end
                  ph_in = 3'd2;
               end
               3'd2: begin
                  if (div_done) begin
                     if (det_ff != '0) begin
                        res_in[idx_ff] = div_quot;
                     end else if (idx_ff == WEIGHT_STEP) begin
                        res_in[idx_ff] = '0;
                     end else if (opa_ff[63]) begin
                        res_in[idx_ff] = MIN32;
                     end else if (opa_ff != '0) begin
                        res_in[idx_ff] = MAX32;
                     end else begin
                        res_in[idx_ff] = '0;
                     end
                     ph_in = 3'd0;
                     if (idx_ff == WEIGHT_STEP) begin
                        idx_in   = '0;
                        state_in = ST_OUT;
                     end else begin
                        idx_in = idx_ff + 1'b1;
                     end
                  end
               end
               default: ph_in = 3'd0;
            endcase
         end
         // Hold the result until the beat is taken.
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state and the Jacobian sums reset; datapath registers do not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ph_ff    <= '0;
         idx_ff   <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         last_ff  <= 1'b0;
         for (int k = 0; k < ENTRIES; k++) begin
            sum_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
         idx_ff   <= idx_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         last_ff  <= last_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      g_ff    <= g_in;
      w_ff    <= w_in;
      jq_ff   <= jq_in;
      cof_ff  <= cof_in;
      res_ff  <= res_in;
      opa_ff  <= opa_in;
      p1_ff   <= p1_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      det_ff  <= det_in;
   end

   assign rsp_valid         = (state_ff == ST_OUT);
   assign rsp_inv_00        = res_ff[0];
   assign rsp_inv_01        = res_ff[1];
   assign rsp_inv_02        = res_ff[2];
   assign rsp_inv_10        = res_ff[3];
   assign rsp_inv_11        = res_ff[4];
   assign rsp_inv_12        = res_ff[5];
   assign rsp_inv_20        = res_ff[6];
   assign rsp_inv_21        = res_ff[7];
   assign rsp_inv_22        = res_ff[8];
   assign rsp_scaled_weight = res_ff[9];
   assign rsp_jacobian_det  = det_ff;
   assign rsp_singular      = (det_ff == '0);

endmodule

// ===== tb/prism_jacobian_inverse_and_weight_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the prism Jacobian inverse and point weight core.
module prism_jacobian_inverse_and_weight_core_test;
   import pjw_pkg::*;

   localparam int NODES       = NODES_DEFAULT;
   localparam int FRAC        = FRAC_BITS_DEFAULT;
   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_WAIT  = 800;
   localparam int RANDOM_PTS  = 312;

   typedef logic signed [127:0] wide_type;

   // One node beat on the request side.
   typedef struct {
      logic signed [31:0] cx, cy, cz, gxi, geta, gzeta, weight;
   } node_beat_type;

   // One solved integration point.
   typedef struct {
      logic signed [31:0] inv[9];
      logic signed [31:0] det;
      logic signed [31:0] weight;
      logic               singular;
   } point_solution_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_coord_x = '0, req_coord_y = '0, req_coord_z = '0;
   logic signed [31:0] req_grad_xi = '0, req_grad_eta = '0, req_grad_zeta = '0;
   logic signed [31:0] req_point_weight = '0;
   logic csr_wr_en = 1'b0;
   logic [VOL_W-1:0] csr_wr_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_inv_00, rsp_inv_01, rsp_inv_02, rsp_inv_10, rsp_inv_11;
   logic signed [31:0] rsp_inv_12, rsp_inv_20, rsp_inv_21, rsp_inv_22;
   logic signed [31:0] rsp_jacobian_det, rsp_scaled_weight;
   logic rsp_singular;

   prism_jacobian_inverse_and_weight_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y), .req_coord_z(req_coord_z),
      .req_grad_xi(req_grad_xi), .req_grad_eta(req_grad_eta),
      .req_grad_zeta(req_grad_zeta), .req_point_weight(req_point_weight),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_inv_00(rsp_inv_00), .rsp_inv_01(rsp_inv_01), .rsp_inv_02(rsp_inv_02),
      .rsp_inv_10(rsp_inv_10), .rsp_inv_11(rsp_inv_11), .rsp_inv_12(rsp_inv_12),
      .rsp_inv_20(rsp_inv_20), .rsp_inv_21(rsp_inv_21), .rsp_inv_22(rsp_inv_22),
      .rsp_jacobian_det(rsp_jacobian_det), .rsp_scaled_weight(rsp_scaled_weight),
      .rsp_singular(rsp_singular)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   node_beat_type      pending_nodes[$];
   point_solution_type expected_points[$];
   node_beat_type      node_on_bus;
   int unsigned        send_idle_pct = 0;
   int unsigned        recv_stall_pct = 0;
   int unsigned        fail_count = 0;
   int unsigned        quiet_cycles = 0;

   // Predictor state: Jacobian sums, node count and the volume register.
   logic signed [63:0] jac_sum[9];
   int unsigned        nodes_seen;
   logic [VOL_W-1:0]   volume_reg;

   function automatic longint clamp32(wide_type v);
      if (v > wide_type'(32'sh7FFF_FFFF)) return 64'sh7FFF_FFFF;
      if (v < -wide_type'(64'sh8000_0000)) return -64'sh8000_0000;
      return longint'(v);
   endfunction

   function automatic longint clamp64(wide_type v);
      if (v > wide_type'(MAX64)) return MAX64;
      if (v < wide_type'(MIN64)) return MIN64;
      return longint'(v);
   endfunction

   // Add half an output step, floor, then saturate to 32 bits.
   function automatic longint round_half_up(wide_type v, int s);
      wide_type r;
      r = (v + (wide_type'(1) <<< (s - 1))) >>> s;
      return clamp32(r);
   endfunction

   // Fold one node into the sums; after the last node, solve the point.
   task automatic accumulate_node(input node_beat_type n);
      longint             xs[3], gs[3], jq[9], cof[9], det, c, vol;
      wide_type           acc;
      point_solution_type sol;
      xs[0] = n.cx;  xs[1] = n.cy;   xs[2] = n.cz;
      gs[0] = n.gxi; gs[1] = n.geta; gs[2] = n.gzeta;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            jac_sum[3*i+j] = clamp64(wide_type'(jac_sum[3*i+j]) + wide_type'(xs[i] * gs[j]));
      if (nodes_seen + 1 < NODES) begin
         nodes_seen++;
         return;
      end
      nodes_seen = 0;
      for (int k = 0; k < 9; k++) begin
         jq[k] = round_half_up(wide_type'(jac_sum[k]), FRAC);
         jac_sum[k] = '0;
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            cof[3*i+j] = clamp64(
               wide_type'(jq[3*((i+1)%3)+(j+1)%3]) * wide_type'(jq[3*((i+2)%3)+(j+2)%3]) -
               wide_type'(jq[3*((i+1)%3)+(j+2)%3]) * wide_type'(jq[3*((i+2)%3)+(j+1)%3]));
      acc = '0;
      for (int j = 0; j < 3; j++)
         acc = acc + wide_type'(jq[j]) * wide_type'(cof[j]);
      det = round_half_up(acc, 2 * FRAC);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            c = cof[3*j+i];
            if (det == 0)
               sol.inv[3*i+j] = c > 0 ? MAX32 : (c < 0 ? MIN32 : 32'sd0);
            else
               sol.inv[3*i+j] = clamp32(wide_type'(c) / wide_type'(det));
         end
      vol = (volume_reg == 0) ? 1 : longint'(volume_reg);
      sol.det      = det;
      sol.weight   = clamp32((wide_type'(longint'(n.weight)) * wide_type'(det)) /
                             wide_type'(2 * vol));
      sol.singular = (det == 0);
      expected_points.push_back(sol);
   endtask

   // Request driver: holds a stalled beat, otherwise loads the next node or idles.
   always @(posedge clock) begin
      logic next_valid;
      next_valid = req_valid;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            accumulate_node(node_on_bus);
            next_valid = 1'b0;
         end
         if (!next_valid && pending_nodes.size() > 0 &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            node_on_bus = pending_nodes.pop_front();
            req_coord_x      <= node_on_bus.cx;
            req_coord_y      <= node_on_bus.cy;
            req_coord_z      <= node_on_bus.cz;
            req_grad_xi      <= node_on_bus.gxi;
            req_grad_eta     <= node_on_bus.geta;
            req_grad_zeta    <= node_on_bus.gzeta;
            req_point_weight <= node_on_bus.weight;
            next_valid = 1'b1;
         end
      end
      req_valid <= next_valid;
   end

   // Result monitor: random stall, and each accepted beat checked against the oldest point.
   always @(posedge clock) begin
      point_solution_type want;
      logic signed [31:0] got[9];
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_inv_00, rsp_inv_01, rsp_inv_02, rsp_inv_10, rsp_inv_11,
                 rsp_inv_12, rsp_inv_20, rsp_inv_21, rsp_inv_22};
         if (expected_points.size() == 0) begin
            $error("result beat with no point outstanding");
            fail_count++;
         end else begin
            want = expected_points.pop_front();
            for (int k = 0; k < 9; k++)
               if (got[k] !== want.inv[k]) begin
                  $error("inv_%0d%0d: expected %0d, got %0d", k / 3, k % 3, want.inv[k], got[k]);
                  fail_count++;
               end
            if (rsp_jacobian_det !== want.det) begin
               $error("jacobian_det: expected %0d, got %0d", want.det, rsp_jacobian_det);
               fail_count++;
            end
            if (rsp_scaled_weight !== want.weight) begin
               $error("scaled_weight: expected %0d, got %0d", want.weight, rsp_scaled_weight);
               fail_count++;
            end
            if (rsp_singular !== want.singular) begin
               $error("singular: expected %0d, got %0d", want.singular, rsp_singular);
               fail_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // Watchdog on cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic signed [31:0] small_value(int unsigned span);
      return $signed($urandom_range(0, 2 * span)) - $signed(span);
   endfunction

   function automatic logic signed [31:0] edge_value();
      case ($urandom_range(0, 6))
         0: return 32'sd0;
         1: return 32'sd1;
         2: return -32'sd1;
         3: return 32'sh0001_0000;
         4: return MIN32;
         5: return MAX32;
         default: return $urandom;
      endcase
   endfunction

   // Queue one point of six nodes in one of several styles.
   //  0: well-formed, moderate coordinates and gradients
   //  1: flat element (all z zero), so the determinant is zero
   //  2: full-range random
   //  3: mix of extreme values
   task automatic queue_point(input int style);
      node_beat_type n;
      for (int i = 0; i < NODES; i++) begin
         case (style)
            0, 1: begin
               n.cx = small_value(32'h0008_0000);
               n.cy = small_value(32'h0008_0000);
               n.cz = (style == 1) ? 32'sd0 : small_value(32'h0008_0000);
               n.gxi = small_value(32'h0002_0000);
               n.geta = small_value(32'h0002_0000);
               n.gzeta = small_value(32'h0002_0000);
               n.weight = small_value(32'h0004_0000);
            end
            2: begin
               n.cx = $urandom;  n.cy = $urandom;   n.cz = $urandom;
               n.gxi = $urandom; n.geta = $urandom; n.gzeta = $urandom;
               n.weight = $urandom;
            end
            default: begin
               n.cx = edge_value();  n.cy = edge_value();   n.cz = edge_value();
               n.gxi = edge_value(); n.geta = edge_value(); n.gzeta = edge_value();
               n.weight = edge_value();
            end
         endcase
         pending_nodes.push_back(n);
      end
   endtask

   task automatic queue_directed_point(input logic signed [31:0] c, input logic signed [31:0] g,
                                       input logic signed [31:0] w);
      node_beat_type n;
      for (int i = 0; i < NODES; i++) begin
         n = '{c, c, c, g, g, g, w};
         pending_nodes.push_back(n);
      end
   endtask

   // Idle means no node waiting, none on the bus and no point outstanding.
   task automatic wait_drained();
      while (pending_nodes.size() > 0 || req_valid || expected_points.size() > 0)
         @(negedge clock);
   endtask

   task automatic write_volume(input logic [VOL_W-1:0] v);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      volume_reg = v;
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Stimulus: reset, a directed part, then random phases with varied idling and volume.
   initial begin
      logic [VOL_W-1:0] vols[5];
      int unsigned      send_pct[5], recv_pct[5];
      node_beat_type    n;
      int               r;
      for (int k = 0; k < 9; k++) jac_sum[k] = '0;
      nodes_seen = 0;
      volume_reg = VOL_RESET;
      vols     = '{31'd1, 31'd0, 31'h7FFF_FFFF, VOL_RESET, 31'd196608};
      send_pct = '{0, 53, 0, 38, 0};
      recv_pct = '{0, 0, 53, 38, 0};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: all zero, saturating extremes, a diagonal point and a flat element.
      queue_directed_point(32'sd0, 32'sd0, MAX32);
      queue_directed_point(MAX32, MIN32, MIN32);
      for (int i = 0; i < NODES; i++) begin
         n = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sh0001_0000};
         case (i % 3)
            0: begin n.cx = 32'sh0002_0000; n.gxi = 32'sh0000_8000; end
            1: begin n.cy = 32'sh0001_0000; n.geta = 32'sh0001_0000; end
            default: begin n.cz = -32'sh0000_8000; n.gzeta = 32'sh0002_0000; end
         endcase
         pending_nodes.push_back(n);
      end
      queue_point(1);
      wait_drained();

      for (int p = 0; p < 5; p++) begin
         write_volume(vols[p]);
         send_idle_pct  = send_pct[p];
         recv_stall_pct = recv_pct[p];
         for (int k = 0; k < RANDOM_PTS / 5; k++) begin
            r = $urandom_range(0, 99);
            queue_point(r < 70 ? 0 : (r < 80 ? 1 : (r < 90 ? 2 : 3)));
         end
         wait_drained();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
